// ===== src/bcz_pkg.sv =====
// shared types and constants for the backface cull and z average block
`default_nettype none
package bcz_pkg;
   localparam int COORD_W = 32;
   localparam int TAG_W = 12;
   localparam int COUNT_W = 3;
   localparam int CMD_LOAD = 0;

   // store depth, corner limit and ordinal wrap
   localparam int VERTEX_DEPTH = 1024;
   localparam int MAX_CORNERS = 4;
   localparam int MAX_POLYGONS = 4096;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } vertex_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_PIVOT, ST_WAIT_PIVOT, ST_MUL, ST_MUL_WAIT, ST_CHECK,
      ST_RD_CORNER, ST_WAIT_CORNER, ST_DIVIDE, ST_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // latch request
      logic write_vtx;   // store the request vertex
      logic read_pivot;  // read pivot from store
      logic load_diff;   // form difference vector
      logic mul_step;    // one product of the dot
      logic drop;        // back-facing polygon dropped
      logic read_corner; // read next corner
      logic add_z;       // accumulate z
      logic div_start;   // start divider
      logic div_step;    // one divider bit
      logic load_out;    // present response
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_load;
      logic back_facing;
      logic corners_done;
      logic mul_done;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

// ===== src/bcz_if.sv =====
// valid/ready channel interface
`default_nettype none
interface bcz_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic valid;
   logic ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/bcz_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module bcz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write or read one word
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== src/bcz_ctrl.sv =====
// controller state machine for the cull block
`default_nettype none
module bcz_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire bcz_pkg::stat_type  stat,
   output bcz_pkg::cmd_type        cmd
);
   import bcz_pkg::*;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_RD_PIVOT;
            end
         end
         ST_RD_PIVOT: begin
            if (stat.is_load) begin
               cmd.write_vtx = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.read_pivot = 1'b1;
               state_in = ST_WAIT_PIVOT;
            end
         end
         // keep the pivot on the store output for the difference step
         ST_WAIT_PIVOT: begin
            cmd.read_pivot = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_diff = 1'b1;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            cmd.mul_step = 1'b1;
            if (stat.mul_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.back_facing) begin
               cmd.drop = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD_CORNER;
            end
         end
         ST_RD_CORNER: begin
            if (stat.corners_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIVIDE;
            end else begin
               cmd.read_corner = 1'b1;
               state_in = ST_WAIT_CORNER;
            end
         end
         ST_WAIT_CORNER: begin
            cmd.add_z = 1'b1;
            state_in = ST_RD_CORNER;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a response is only launched from the emit state
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> state_ff == ST_EMIT) else $error("stray response load");
   // a pending response is never overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff) else $error("response lost");
   // requests only taken when idle
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

// ===== src/bcz_dp.sv =====
// datapath: vertex store, dot product, z sum and divider
`default_nettype none
module bcz_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_command,
   input  wire logic [9:0]        req_vertex_slot,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic [11:0]       req_poly_tag,
   input  wire logic [2:0]        req_corner_count,
   input  wire logic [9:0]        req_corner_a,
   input  wire logic [9:0]        req_corner_b,
   input  wire logic [9:0]        req_corner_c,
   input  wire logic [9:0]        req_corner_d,
   input  wire logic              req_last_polygon,
   input  wire bcz_pkg::cmd_type  cmd,
   output bcz_pkg::stat_type      stat,
   output logic [11:0]            rsp_visible_tag,
   output logic signed [31:0]     rsp_z_average,
   output logic [11:0]            rsp_visible_ordinal
);
   import bcz_pkg::*;
   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int PW = $clog2(MAX_POLYGONS);
   localparam int LIMIT = (MAX_CORNERS < 4) ? MAX_CORNERS : 4;

   // latched request
   logic cmd_ff, last_ff;
   logic [9:0] slot_ff;
   logic [9:0] corner_ff [4];
   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [11:0] tag_ff;
   logic [2:0] count_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         slot_ff <= req_vertex_slot;
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
         cz_ff <= req_coord_z;
         tag_ff <= req_poly_tag;
         count_ff <= (req_corner_count > 3'(LIMIT)) ? 3'(LIMIT) : req_corner_count;
         corner_ff[0] <= req_corner_a;
         corner_ff[1] <= req_corner_b;
         corner_ff[2] <= req_corner_c;
         corner_ff[3] <= req_corner_d;
         last_ff <= req_last_polygon;
      end
   end

   // vertex store
   logic [2:0] idx_ff, idx_in;
   logic [AW-1:0] ram_addr;
   vertex_type rd_vtx;
   always_comb begin
      if (cmd.write_vtx) ram_addr = slot_ff[AW-1:0];
      else if (cmd.read_pivot) ram_addr = corner_ff[1][AW-1:0];
      else ram_addr = corner_ff[idx_ff[1:0]][AW-1:0];
   end
   bcz_ram #(.WIDTH($bits(vertex_type)), .DEPTH(VERTEX_DEPTH)) u_store (
      .clock(clock), .wr_en(cmd.write_vtx), .addr(ram_addr),
      .wr_data({cx_ff, cy_ff, cz_ff}), .rd_data(rd_vtx));

   // dot product, one 32x32 product per cycle
   logic [31:0] na_ff [3];
   logic [31:0] nb_ff [3];
   logic [1:0] mi_ff;
   logic [31:0] dot_ff;
   logic signed [63:0] prod_ff;
   logic prod_v_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         na_ff[0] <= cx_ff - rd_vtx.x;
         na_ff[1] <= cy_ff - rd_vtx.y;
         na_ff[2] <= cz_ff - rd_vtx.z;
         nb_ff[0] <= 32'd0 - rd_vtx.x;
         nb_ff[1] <= 32'd0 - rd_vtx.y;
         nb_ff[2] <= 32'd0 - rd_vtx.z;
         mi_ff <= '0;
         dot_ff <= '0;
         prod_v_ff <= 1'b0;
      end else if (cmd.mul_step) begin
         if (mi_ff != 2'd3) begin
            prod_ff <= $signed(na_ff[mi_ff]) * $signed(nb_ff[mi_ff]);
            mi_ff <= mi_ff + 2'd1;
         end
         prod_v_ff <= (mi_ff != 2'd3);
         if (prod_v_ff) dot_ff <= dot_ff + prod_ff[47:16];
      end
   end
   assign stat.mul_done = (mi_ff == 2'd3) && !prod_v_ff;
   assign stat.back_facing = dot_ff[31];
   assign stat.is_load = (cmd_ff == 1'(CMD_LOAD));

   // z sum over corners
   logic [31:0] sum_ff;
   always_comb idx_in = idx_ff + 3'd1;
   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         idx_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.add_z) begin
         sum_ff <= sum_ff + rd_vtx.z;
         idx_ff <= idx_in;
      end
   end
   assign stat.corners_done = (idx_ff >= count_ff);

   // restoring divider on magnitude
   logic [31:0] quo_ff, rem_ff;
   logic [5:0] dcnt_ff;
   logic neg_ff;
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {30'd0, count_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= sum_ff[31];
         quo_ff <= sum_ff[31] ? 32'd0 - sum_ff : sum_ff;
         rem_ff <= '0;
         dcnt_ff <= 6'd32;
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 6'd1;
      end
   end
   assign stat.div_done = (dcnt_ff == 6'd0);

   // ordinal counter and response register
   logic [PW-1:0] ord_ff;
   always_ff @(posedge clock) begin
      if (reset) ord_ff <= '0;
      else if (cmd.load_out) ord_ff <= last_ff ? '0 : ord_ff + PW'(1);
      else if (cmd.drop && last_ff) ord_ff <= '0;
   end
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_visible_tag <= tag_ff;
         rsp_z_average <= (count_ff == 3'd0) ? 32'd0 :
                          (neg_ff ? 32'd0 - quo_ff : quo_ff);
         rsp_visible_ordinal <= 12'(ord_ff);
      end
   end
endmodule
`default_nettype wire

// ===== src/backface_cull_zaverage.sv =====
// top level of the backface cull and z average block
// Usage: requests arrive on req (valid/ready). A load request (command 0)
// writes one 16.16 vertex into the 1024 entry store and returns nothing.
// A polygon request (command 1) reads its pivot vertex, forms a 16.16 dot
// product with one multiplier (three products in sequence), and if
// front facing sums the corner z values (one store read each) and divides
// by the count with a one bit per cycle divider of 32 steps. A visible
// polygon gives one response on rsp carrying tag, mean z and ordinal.
// One request is in work at a time; ready is high only when idle.
// Reset clears the controller and the ordinal counter; the vertex store is
// undefined until written. A stalled response is held in its register and
// the block waits in the emit step until the previous response is taken.
`default_nettype none
module backface_cull_zaverage (
   input wire logic clock,
   input wire logic reset,
   bcz_if.sink   req,
   bcz_if.source rsp
);
   import bcz_pkg::*;
   cmd_type cmd;
   stat_type stat;

   bcz_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat(stat), .cmd(cmd));

   bcz_dp u_dp (
      .clock(clock), .reset(reset),
      .req_command(req.payload.command), .req_vertex_slot(req.payload.vertex_slot),
      .req_coord_x(req.payload.coord_x), .req_coord_y(req.payload.coord_y),
      .req_coord_z(req.payload.coord_z), .req_poly_tag(req.payload.poly_tag),
      .req_corner_count(req.payload.corner_count),
      .req_corner_a(req.payload.corner_a), .req_corner_b(req.payload.corner_b),
      .req_corner_c(req.payload.corner_c), .req_corner_d(req.payload.corner_d),
      .req_last_polygon(req.payload.last_polygon),
      .cmd(cmd), .stat(stat),
      .rsp_visible_tag(rsp.payload.visible_tag),
      .rsp_z_average(rsp.payload.z_average),
      .rsp_visible_ordinal(rsp.payload.visible_ordinal));
endmodule
`default_nettype wire

// ===== test/tb_backface_cull_zaverage.sv =====
// testbench for backface_cull_zaverage: directed table, random loads and polygons under idling and stalls
`default_nettype none
module tb_backface_cull_zaverage;
   import bcz_pkg::*;

   localparam logic CMD_POLY = 1'b1;
   localparam int DEPTH = 1024;

   typedef struct packed {
      logic        command;
      logic [9:0]  vertex_slot;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] coord_z;
      logic [11:0] poly_tag;
      logic [2:0]  corner_count;
      logic [9:0]  corner_a;
      logic [9:0]  corner_b;
      logic [9:0]  corner_c;
      logic [9:0]  corner_d;
      logic        last_polygon;
   } poly_req_type;

   typedef struct packed {
      logic [11:0] visible_tag;
      logic [31:0] z_average;
      logic [11:0] visible_ordinal;
   } poly_rsp_type;

   // one directed row: request, and a hand-typed answer where it is obvious
   typedef enum logic [1:0] {ROW_PREDICT, ROW_HIDDEN, ROW_TYPED} row_kind_type;
   typedef struct {
      poly_req_type r;
      row_kind_type kind;
      poly_rsp_type e;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcz_if #(.PAYLOAD_TYPE(poly_req_type)) req_ch ();
   bcz_if #(.PAYLOAD_TYPE(poly_rsp_type)) rsp_ch ();

   backface_cull_zaverage dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   // predictor state
   logic [95:0] vtx_mirror [DEPTH];
   bit written [DEPTH];
   int written_slots [$];
   logic [11:0] ordinal_mirror;
   poly_rsp_type visible_queue [$];

   bit failed = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [31:0] fx_product(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[47:16];
   endfunction

   // apply one request to the mirror; returns 1 with the response when visible
   function automatic bit cull_and_average(poly_req_type r, output poly_rsp_type o);
      logic [31:0] px, py, pz, dot, zsum;
      logic [9:0] corners [4];
      int n;
      bit shown;
      o = '0;
      if (r.command != CMD_POLY) begin
         vtx_mirror[r.vertex_slot] = {r.coord_x, r.coord_y, r.coord_z};
         return 0;
      end
      corners = '{r.corner_a, r.corner_b, r.corner_c, r.corner_d};
      {px, py, pz} = vtx_mirror[r.corner_b];
      dot = fx_product(r.coord_x - px, -px) + fx_product(r.coord_y - py, -py)
            + fx_product(r.coord_z - pz, -pz);
      shown = !dot[31];
      if (shown) begin
         n = (r.corner_count > 4) ? 4 : r.corner_count;
         zsum = '0;
         for (int i = 0; i < n; i++) zsum += vtx_mirror[corners[i]][31:0];
         o.visible_tag = r.poly_tag;
         o.z_average = (n == 0) ? 32'd0 : 32'($signed(zsum) / n);
         o.visible_ordinal = ordinal_mirror;
         ordinal_mirror++;
      end
      if (r.last_polygon) ordinal_mirror = '0;
      return shown;
   endfunction

   // offer one request and record the expected response once accepted
   task automatic offer(poly_req_type r, row_kind_type kind, poly_rsp_type typed);
      poly_rsp_type o;
      bit shown;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      shown = cull_and_average(r, o);
      if (r.command == CMD_LOAD[0] && !written[r.vertex_slot]) begin
         written[r.vertex_slot] = 1;
         written_slots.push_back(r.vertex_slot);
      end
      if (kind == ROW_TYPED) visible_queue.push_back(typed);
      else if (kind == ROW_PREDICT && shown) visible_queue.push_back(o);
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (visible_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic poly_req_type vertex_load(int slot, logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z);
      poly_req_type r;
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(poly_req_type)-1:0];
      r.command = CMD_LOAD[0];
      r.vertex_slot = 10'(slot);
      {r.coord_x, r.coord_y, r.coord_z} = {x, y, z};
      return r;
   endfunction

   function automatic poly_req_type polygon(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            int tag, int cnt, int a, int b, int c, int d,
                                            bit last);
      poly_req_type r;
      r = '0;
      r.command = CMD_POLY;
      r.vertex_slot = 10'($urandom);
      {r.coord_x, r.coord_y, r.coord_z} = {x, y, z};
      r.poly_tag = 12'(tag);
      r.corner_count = 3'(cnt);
      {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {10'(a), 10'(b), 10'(c), 10'(d)};
      r.last_polygon = last;
      return r;
   endfunction

   function automatic int any_slot();
      return written_slots[$urandom_range(written_slots.size() - 1)];
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
         2: return 32'($signed($urandom_range(400)) - 200);
         default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   // random mix: mostly loads and polygons over written slots, some wild coordinates
   task automatic random_items(int n);
      poly_req_type r;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 30 || written_slots.size() < 4) begin
            r = vertex_load($urandom_range(DEPTH - 1), rand_coord(), rand_coord(),
                            rand_coord());
         end else begin
            r = polygon(rand_coord(), rand_coord(), rand_coord(), $urandom_range(4095),
                        $urandom_range(7), any_slot(), any_slot(), any_slot(), any_slot(),
                        $urandom_range(9) == 0);
            if ($urandom_range(3) == 0) begin
               // normal point at the pivot: dot is zero, always visible
               {r.coord_x, r.coord_y, r.coord_z} = vtx_mirror[r.corner_b];
            end
         end
         offer(r, ROW_PREDICT, '0);
      end
   endtask

   // response check
   always @(posedge clock) begin
      poly_rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (visible_queue.size() == 0) begin
            $error("unexpected response tag %0d", got.visible_tag);
            failed = 1;
         end else begin
            want = visible_queue.pop_front();
            if (got.visible_tag !== want.visible_tag) begin
               $error("visible_tag expected %0d got %0d", want.visible_tag, got.visible_tag);
               failed = 1;
            end
            if (got.z_average !== want.z_average) begin
               $error("z_average expected %h got %h", want.z_average, got.z_average);
               failed = 1;
            end
            if (got.visible_ordinal !== want.visible_ordinal) begin
               $error("visible_ordinal expected %0d got %0d", want.visible_ordinal,
                      got.visible_ordinal);
               failed = 1;
            end
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      row_type rows [$];
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      ordinal_mirror = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      rows = '{
         '{vertex_load(0, 0, 0, 0), ROW_HIDDEN, '0},
         '{vertex_load(1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), ROW_HIDDEN, '0},
         '{vertex_load(1, 0, 0, 32'h8000_0000), ROW_HIDDEN, '0},
         '{vertex_load(2, 32'h8000_0000, 32'h8000_0000, 32'hfffd_0000), ROW_HIDDEN, '0},
         '{vertex_load(3, 32'h0001_0000, 0, 0), ROW_HIDDEN, '0},
         // zero pivot, single corner at the top extreme
         '{polygon(0, 0, 0, 4095, 1, 1023, 0, 0, 0, 0), ROW_TYPED,
           '{12'd4095, 32'h7fff_ffff, 12'd0}},
         // zero count: mean is zero
         '{polygon(0, 0, 0, 0, 0, 1023, 0, 1, 2, 0), ROW_TYPED, '{12'd0, 32'd0, 12'd1}},
         // oversized count saturates, last polygon restarts the ordinal
         '{polygon(0, 0, 0, 7, 7, 0, 0, 0, 0, 1), ROW_TYPED, '{12'd7, 32'd0, 12'd2}},
         // z sum wraps to zero
         '{polygon(0, 0, 0, 9, 2, 1, 1, 1, 0, 0), ROW_TYPED, '{12'd9, 32'd0, 12'd0}},
         // back-facing: normal beyond pivot along x
         '{polygon(32'h0002_0000, 0, 0, 5, 3, 0, 3, 1, 0, 0), ROW_HIDDEN, '0},
         // back-facing polygon flagged last still restarts
         '{polygon(32'h0002_0000, 0, 0, 6, 3, 0, 3, 1, 0, 1), ROW_HIDDEN, '0},
         '{polygon(0, 0, 0, 11, 4, 1023, 0, 1, 2, 0), ROW_PREDICT, '0},
         '{polygon(32'h8000_0000, 32'h7fff_ffff, 0, 12, 4, 2, 2, 1, 1023, 0), ROW_PREDICT,
           '0},
         '{polygon(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 13, 3, 1, 1023, 2, 0, 0),
           ROW_PREDICT, '0},
         '{polygon(0, 0, 0, 14, 4, 2, 1, 3, 1023, 1), ROW_PREDICT, '0}
      };
      foreach (rows[i]) offer(rows[i].r, rows[i].kind, rows[i].e);
      settle();

      // idling phases
      random_items(350);
      settle();
      send_idle_pct = 73;
      random_items(250);
      settle();
      send_idle_pct = 0;
      stall_pct = 73;
      random_items(300);
      settle();
      send_idle_pct = 25;
      stall_pct = 25;
      random_items(300);
      settle();

      // long hold-off while requests keep coming
      send_idle_pct = 0;
      stall_pct = 0;
      @(negedge clock);
      hold_off <= 400;
      random_items(200);
      settle();

      if (!failed) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
